### rtl/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

    localparam int NUM_CH    = 4;
    localparam int COUNT_W   = 16;
    localparam int PCT_W     = 7;
    localparam int DUTY_W    = 8;
    localparam int CH_W      = 2;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PCT_FULL  = 100;

    // The scaled width is (percent * |span|) / 100. The quotient is taken as a
    // multiplication by ceil(2^30 / 100) and a shift by 30, which is exact for
    // every product below 2^23.
    localparam int MAG_W       = PCT_W + COUNT_W;
    localparam int RECIP_W     = 24;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 24'd10737419;

    localparam logic [COUNT_W-1:0] MIN_WIDTH_RESET = 16'd100;
    localparam logic [COUNT_W-1:0] MAX_WIDTH_RESET = 16'd200;
    localparam logic [COUNT_W-1:0] PERIOD_RESET    = 16'd2000;

    localparam int HOLD_W = 2;
    localparam logic [HOLD_W-1:0] REFRESH_CYCLES = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_WIDTH = 2'd0,
        REG_MAX_WIDTH = 2'd1,
        REG_PERIOD    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CH_W-1:0]   channel_index;
        logic [DUTY_W-1:0] duty_percent;
    } item_t;

    typedef struct packed {
        logic [NUM_CH-1:0] pin_levels;
        logic              period_start;
        logic [PCT_W-1:0]  read_percent;
    } result_t;

endpackage

### rtl/msp_if.sv
`timescale 1ns / 1ps

interface msp_in_if;
    logic                         valid;
    logic                         ready;
    logic [msp_pkg::CMD_W-1:0]    command;
    logic [msp_pkg::CH_W-1:0]     channel_index;
    logic [msp_pkg::DUTY_W-1:0]   duty_percent;

    modport source (output valid, command, channel_index, duty_percent, input ready);
    modport sink (input valid, command, channel_index, duty_percent, output ready);
endinterface

interface msp_out_if;
    logic                         valid;
    logic                         ready;
    logic [msp_pkg::NUM_CH-1:0]   pin_levels;
    logic                         period_start;
    logic [msp_pkg::PCT_W-1:0]    read_percent;

    modport source (output valid, pin_levels, period_start, read_percent, input ready);
    modport sink (input valid, pin_levels, period_start, read_percent, output ready);
endinterface

interface msp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [msp_pkg::CFG_IDX_W-1:0]  index;
    logic [msp_pkg::COUNT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/msp_width_calc.sv
`timescale 1ns / 1ps

module msp_width_calc (
    input  logic                          clk,
    input  logic [msp_pkg::PCT_W-1:0]     percent,
    input  logic [msp_pkg::COUNT_W-1:0]   min_width,
    input  logic [msp_pkg::COUNT_W-1:0]   max_width,
    output logic [msp_pkg::COUNT_W-1:0]   width
);

    logic signed [msp_pkg::COUNT_W:0]   span;
    logic [msp_pkg::COUNT_W-1:0]        span_mag;
    logic [msp_pkg::MAG_W-1:0]          mag_next;
    logic [msp_pkg::MAG_W-1:0]          mag_reg;
    logic                               neg_reg;
    logic [msp_pkg::PROD_W-1:0]         prod;
    logic [msp_pkg::COUNT_W-1:0]        quot;
    logic [msp_pkg::COUNT_W-1:0]        width_next;
    logic [msp_pkg::COUNT_W-1:0]        width_reg;

    always_comb
    begin
        span     = $signed({1'b0, max_width}) - $signed({1'b0, min_width});
        span_mag = span[msp_pkg::COUNT_W] ? msp_pkg::COUNT_W'(-span)
                                          : span[msp_pkg::COUNT_W-1:0];
        mag_next = {{(msp_pkg::MAG_W - msp_pkg::PCT_W){1'b0}}, percent}
                 * {{(msp_pkg::MAG_W - msp_pkg::COUNT_W){1'b0}}, span_mag};
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= span[msp_pkg::COUNT_W];
    end

    // The quotient truncates toward zero, so the sign is applied after dividing.
    always_comb
    begin
        prod = {{(msp_pkg::PROD_W - msp_pkg::MAG_W){1'b0}}, mag_reg}
             * {{(msp_pkg::PROD_W - msp_pkg::RECIP_W){1'b0}}, msp_pkg::PCT_RECIP};
        quot = prod[msp_pkg::RECIP_SHIFT +: msp_pkg::COUNT_W];
        width_next = neg_reg ? (min_width - quot) : (min_width + quot);
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
    end

    assign width = width_reg;

endmodule

### rtl/msp_tick_engine.sv
`timescale 1ns / 1ps

module msp_tick_engine (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            go,
    input  msp_pkg::item_t                                  item,
    input  logic [msp_pkg::COUNT_W-1:0]                     period,
    input  logic [msp_pkg::NUM_CH-1:0][msp_pkg::COUNT_W-1:0] widths,
    output logic [msp_pkg::NUM_CH-1:0][msp_pkg::PCT_W-1:0]   percent,
    output msp_pkg::result_t                                res,
    output logic                                            set_done
);

    logic [msp_pkg::COUNT_W-1:0]                      count_reg;
    logic [msp_pkg::COUNT_W-1:0]                      count_next;
    logic [msp_pkg::NUM_CH-1:0][msp_pkg::PCT_W-1:0]   percent_reg;
    logic [msp_pkg::NUM_CH-1:0][msp_pkg::PCT_W-1:0]   percent_next;
    logic [msp_pkg::NUM_CH-1:0][msp_pkg::COUNT_W-1:0] latched_reg;
    logic [msp_pkg::NUM_CH-1:0][msp_pkg::COUNT_W-1:0] latched_next;
    logic [msp_pkg::NUM_CH-1:0]                       pins_reg;
    logic [msp_pkg::NUM_CH-1:0]                       pins_next;
    logic                                             start;
    logic [msp_pkg::PCT_W-1:0]                        sat_pct;

    always_comb
    begin
        count_next   = count_reg;
        percent_next = percent_reg;
        latched_next = latched_reg;
        pins_next    = pins_reg;
        start        = 1'b0;
        sat_pct      = (item.duty_percent > msp_pkg::DUTY_W'(msp_pkg::PCT_FULL))
                     ? msp_pkg::PCT_W'(msp_pkg::PCT_FULL)
                     : item.duty_percent[msp_pkg::PCT_W-1:0];
        if (go)
        begin
            case (item.command)
                msp_pkg::CMD_TICK:
                begin
                    if (period > count_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            latched_next = widths;
                            pins_next    = '1;
                            start        = 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < msp_pkg::NUM_CH; i++)
                            begin
                                if (latched_reg[i] == count_reg)
                                begin
                                    pins_next[i] = 1'b0;
                                end
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = '0;
                    end
                end
                msp_pkg::CMD_SET:
                begin
                    percent_next[item.channel_index] = sat_pct;
                end
                msp_pkg::CMD_READ:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            percent_reg <= '0;
            latched_reg <= '0;
            pins_reg    <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            percent_reg <= percent_next;
            latched_reg <= latched_next;
            pins_reg    <= pins_next;
        end
    end

    always_comb
    begin
        res.pin_levels   = pins_next;
        res.period_start = start;
        res.read_percent = percent_next[item.channel_index];
        set_done         = go && (item.command == msp_pkg::CMD_SET);
    end

    assign percent = percent_reg;

endmodule

### rtl/multi_channel_servo_pwm_core.sv
`timescale 1ns / 1ps

// Four-channel servo PWM core. Each accepted item is held in an input register
// and produces one result, held in an output register; ticks, sets and reads
// are taken one per cycle while the output accepts them. Pulse widths are
// scaled from the stored percentages by a two-stage multiply pipeline per
// channel, so a tick that follows a set or a register write waits until those
// widths are refreshed. The pipeline is also refreshed after reset, during
// which ticks are held off.
module multi_channel_servo_pwm_core (
    input  logic       clk,
    input  logic       rst_n,
    msp_cfg_if.sink    cfg,
    msp_in_if.sink     item,
    msp_out_if.source  result
);

    logic [msp_pkg::COUNT_W-1:0]                      min_reg;
    logic [msp_pkg::COUNT_W-1:0]                      max_reg;
    logic [msp_pkg::COUNT_W-1:0]                      period_reg;
    logic [msp_pkg::HOLD_W-1:0]                       hold_reg;
    logic [msp_pkg::HOLD_W-1:0]                       hold_next;
    logic                                             s1_valid_reg;
    logic                                             s1_valid_next;
    msp_pkg::item_t                                   s1_item_reg;
    logic                                             out_valid_reg;
    logic                                             out_valid_next;
    msp_pkg::result_t                                 result_reg;
    msp_pkg::result_t                                 eng_res;
    logic                                             set_done;
    logic                                             cfg_write;
    logic                                             in_take;
    logic                                             out_free;
    logic                                             s1_go;
    logic [msp_pkg::NUM_CH-1:0][msp_pkg::PCT_W-1:0]   percent;
    logic [msp_pkg::NUM_CH-1:0][msp_pkg::COUNT_W-1:0] widths;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= msp_pkg::MIN_WIDTH_RESET;
            max_reg    <= msp_pkg::MAX_WIDTH_RESET;
            period_reg <= msp_pkg::PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                msp_pkg::REG_MIN_WIDTH: min_reg    <= cfg.data;
                msp_pkg::REG_MAX_WIDTH: max_reg    <= cfg.data;
                msp_pkg::REG_PERIOD:    period_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < msp_pkg::NUM_CH; g++)
    begin : g_width
        msp_width_calc u_width_calc (
            .clk       (clk),
            .percent   (percent[g]),
            .min_width (min_reg),
            .max_width (max_reg),
            .width     (widths[g])
        );
    end

    assign out_free    = !out_valid_reg || result.ready;
    assign s1_go       = s1_valid_reg && out_free
                      && !((s1_item_reg.command == msp_pkg::CMD_TICK) && (hold_reg != '0));
    assign item.ready  = !s1_valid_reg || s1_go;
    assign in_take     = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_go ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
        if (cfg_write || set_done)
        begin
            hold_next = msp_pkg::REFRESH_CYCLES;
        end
        else if (hold_reg != '0)
        begin
            hold_next = hold_reg - 1'b1;
        end
        else
        begin
            hold_next = hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_reg      <= msp_pkg::REFRESH_CYCLES;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.command       <= item.command;
            s1_item_reg.channel_index <= item.channel_index;
            s1_item_reg.duty_percent  <= item.duty_percent;
        end
        if (s1_go)
        begin
            result_reg <= eng_res;
        end
    end

    msp_tick_engine u_tick_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (s1_go),
        .item     (s1_item_reg),
        .period   (period_reg),
        .widths   (widths),
        .percent  (percent),
        .res      (eng_res),
        .set_done (set_done)
    );

    assign result.valid        = out_valid_reg;
    assign result.pin_levels   = result_reg.pin_levels;
    assign result.period_start = result_reg.period_start;
    assign result.read_percent = result_reg.read_percent;

    a_tick_waits_for_widths: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && (s1_item_reg.command == msp_pkg::CMD_TICK)) |-> (hold_reg == '0))
        else $error("tick processed while pulse widths were being refreshed");

    a_set_starts_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && (s1_item_reg.command == msp_pkg::CMD_SET)) |=> (hold_reg != '0))
        else $error("set item did not start a width refresh");

    a_start_all_high: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.period_start) |-> (result.pin_levels == '1))
        else $error("period start reported without every pin high");

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.read_percent <= msp_pkg::PCT_W'(msp_pkg::PCT_FULL)))
        else $error("stored percentage above full scale");

endmodule
